/* rtl/sact_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sact_pkg
// Shared geometry, codes and types of the set-associative cache tag controller.
// ----------------------------------------------------------------------------
package sact_pkg;

	localparam int SETS      = 256;
	localparam int WAYS      = 4;
	localparam int ADDR_BITS = 32;

	localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int AGE_W = WAY_W;

	// request kinds; the spare code behaves as a write
	typedef logic [1:0] kind_t;
	localparam kind_t KIND_READ  = 2'd0;
	localparam kind_t KIND_WRITE = 2'd1;
	localparam kind_t KIND_INVAL = 2'd2;
	localparam kind_t KIND_SPARE = 2'd3;

	// configuration register indexes
	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_POLICY    = 2'd0;
	localparam reg_idx_t REG_OFFSET    = 2'd1;
	localparam reg_idx_t REG_INDEX     = 2'd2;
	localparam reg_idx_t REG_INCLUSIVE = 2'd3;

	localparam logic POLICY_LRU  = 1'b0;
	localparam logic POLICY_FIFO = 1'b1;

	typedef struct packed {
		logic                 valid;
		logic                 dirty;
		logic [AGE_W-1:0]     age;
		logic [ADDR_BITS-1:0] tag;
		logic [ADDR_BITS-1:0] addr;
	} line_t;

	typedef line_t [WAYS-1:0] row_t;

	localparam int ROW_W = $bits(row_t);

	typedef struct packed {
		kind_t                kind;
		logic [ADDR_BITS-1:0] addr;
		logic [ADDR_BITS-1:0] tag;
	} req_t;

	typedef struct packed {
		logic policy;
		logic inclusive;
	} mode_t;

	typedef struct packed {
		logic                 hit;
		logic                 evicted;
		logic [ADDR_BITS-1:0] victim;
		logic                 write_back;
	} res_t;

	// contents of a set that was never written
	function automatic row_t reset_row();
		row_t r;
		for (int w = 0; w < WAYS; w++) begin
			r[w].valid = 1'b0;
			r[w].dirty = 1'b0;
			r[w].age   = AGE_W'(w);
			r[w].tag   = '0;
			r[w].addr  = '0;
		end
		return r;
	endfunction

endpackage

/* rtl/sact_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sact_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sact_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/sact_lookup.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sact_lookup
// Tag match, victim choice and age update for one set row.
// ----------------------------------------------------------------------------
module sact_lookup (
	input  sact_pkg::row_t  row,
	input  sact_pkg::req_t  req,
	input  sact_pkg::mode_t mode,
	output sact_pkg::row_t  new_row,
	output sact_pkg::res_t  res
);

	// move one way to newest; ways above its rank slide down by one
	function automatic sact_pkg::row_t make_newest(sact_pkg::row_t r,
		logic [sact_pkg::WAY_W-1:0] w);
		sact_pkg::row_t o;
		logic [sact_pkg::AGE_W-1:0] a;
		o = r;
		a = r[w].age;
		for (int v = 0; v < sact_pkg::WAYS; v++) begin
			if (r[v].age > a) begin
				o[v].age = r[v].age - 1'b1;
			end
		end
		o[w].age = sact_pkg::AGE_W'(sact_pkg::WAYS - 1);
		return o;
	endfunction

	logic                       found;
	logic [sact_pkg::WAY_W-1:0] hit_way;
	logic                       has_free;
	logic [sact_pkg::WAY_W-1:0] free_way;
	logic [sact_pkg::AGE_W:0]   best_age;
	logic [sact_pkg::WAY_W-1:0] old_way;
	logic [sact_pkg::WAY_W-1:0] fill_way;
	logic [sact_pkg::WAY_W-1:0] line_way;

	always_comb begin
		found    = 1'b0;
		hit_way  = '0;
		has_free = 1'b0;
		free_way = '0;
		// walk downward so the lowest way wins
		for (int w = sact_pkg::WAYS - 1; w >= 0; w--) begin
			if (row[w].valid && (row[w].tag == req.tag)) begin
				found   = 1'b1;
				hit_way = sact_pkg::WAY_W'(w);
			end
			if (!row[w].valid) begin
				has_free = 1'b1;
				free_way = sact_pkg::WAY_W'(w);
			end
		end
		best_age = '1;
		old_way  = '0;
		for (int w = 0; w < sact_pkg::WAYS; w++) begin
			if ({1'b0, row[w].age} < best_age) begin
				best_age = {1'b0, row[w].age};
				old_way  = sact_pkg::WAY_W'(w);
			end
		end
	end

	assign fill_way = has_free ? free_way : old_way;
	assign line_way = found ? hit_way : fill_way;

	always_comb begin
		new_row        = row;
		res.hit        = found;
		res.evicted    = 1'b0;
		res.victim     = '0;
		res.write_back = 1'b0;
		case (req.kind)
			sact_pkg::KIND_INVAL: begin
				if (found) begin
					res.write_back          = mode.inclusive && row[hit_way].dirty;
					new_row[hit_way].valid  = 1'b0;
					new_row[hit_way].dirty  = 1'b0;
				end
			end
			default: begin
				if (found) begin
					if (mode.policy == sact_pkg::POLICY_LRU) begin
						new_row = make_newest(row, hit_way);
					end
				end else begin
					if (!has_free) begin
						res.evicted    = 1'b1;
						res.victim     = row[old_way].addr;
						res.write_back = row[old_way].dirty;
					end
					new_row                  = make_newest(row, fill_way);
					new_row[fill_way].valid  = 1'b1;
					new_row[fill_way].dirty  = 1'b0;
					new_row[fill_way].tag    = req.tag;
					new_row[fill_way].addr   = req.addr;
				end
				if (req.kind != sact_pkg::KIND_READ) begin
					new_row[line_way].dirty = 1'b1;
				end
			end
		endcase
	end

endmodule

/* rtl/set_assoc_cache_tag_controller.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_controller
// Tag store of a set-associative write-back, write-allocate cache.
// ----------------------------------------------------------------------------
// Flow: a request's set row is read on accept, the row is updated and the
//   result registered in S_LOOK; no new request is taken until that
//   read-modify-write of the set RAM completes, and a held result adds stall.
// Reset: config returns to LRU, offset 5, index 8, not inclusive; per-set
//   row-valid flops clear at once so every line reads invalid, no sweep.
// ----------------------------------------------------------------------------
module set_assoc_cache_tag_controller (
	input  logic        clk,
	input  logic        arst_n,
	// request stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] address
	input  logic [1:0]  s_tuser,   // [1:0] kind
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [0] hit, [1] evicted, [33:2] victim_address,
	                               // [34] write_back, [39:35] zero
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_LOOK = 2'b10
	} state_t;

	state_t state_q;

	// configuration registers
	logic       policy_q;
	logic [3:0] offset_q;
	logic [3:0] index_q;
	logic       inclusive_q;

	logic               cfg_wr;
	sact_pkg::reg_idx_t cfg_idx;

	assign pready  = 1'b1;
	assign cfg_idx = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q    <= sact_pkg::POLICY_LRU;
			offset_q    <= 4'd5;
			index_q     <= 4'd8;
			inclusive_q <= 1'b0;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				sact_pkg::REG_POLICY:    policy_q    <= pwdata[0];
				sact_pkg::REG_OFFSET:    offset_q    <= pwdata[3:0];
				sact_pkg::REG_INDEX:     index_q     <= pwdata[3:0];
				sact_pkg::REG_INCLUSIVE: inclusive_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			sact_pkg::REG_POLICY:    prdata = {31'd0, policy_q};
			sact_pkg::REG_OFFSET:    prdata = {28'd0, offset_q};
			sact_pkg::REG_INDEX:     prdata = {28'd0, index_q};
			sact_pkg::REG_INCLUSIVE: prdata = {31'd0, inclusive_q};
			default:                 prdata = '0;
		endcase
	end

	// address split at accept time
	logic                            in_acc;
	logic [sact_pkg::ADDR_BITS-1:0]  idx_mask;
	logic [sact_pkg::ADDR_BITS-1:0]  set_full;
	logic [sact_pkg::SET_W-1:0]      in_set;
	logic [sact_pkg::ADDR_BITS-1:0]  in_tag;
	logic [4:0]                      tag_shift;

	assign s_tready  = (state_q == S_IDLE);
	assign in_acc    = s_tvalid && s_tready;
	assign idx_mask  = (sact_pkg::ADDR_BITS'(1) << index_q) - 1'b1;
	assign set_full  = (s_tdata >> offset_q) & idx_mask;
	// SETS is a power of two, so the modulo is the low bits
	assign in_set    = set_full[sact_pkg::SET_W-1:0];
	assign tag_shift = {1'b0, offset_q} + {1'b0, index_q};
	assign in_tag    = s_tdata >> tag_shift;

	// request held through the lookup
	sact_pkg::req_t              req_s1;
	logic [sact_pkg::SET_W-1:0]  set_s1;
	logic                        rowv_s1;

	// a set row counts as written once its flop is set; until then it reads
	// as the reset contents
	logic [sact_pkg::SETS-1:0] row_valid_q;

	logic           out_free;
	logic           done;
	sact_pkg::row_t ram_rdata;
	sact_pkg::row_t cur_row;
	sact_pkg::row_t new_row;
	sact_pkg::res_t res;
	sact_pkg::mode_t mode;

	assign out_free = !m_tvalid || m_tready;
	assign done     = (state_q == S_LOOK) && out_free;
	assign cur_row  = rowv_s1 ? ram_rdata : sact_pkg::reset_row();
	assign mode     = '{policy: policy_q, inclusive: inclusive_q};

	always_ff @(posedge clk) begin
		if (in_acc) begin
			req_s1.kind <= s_tuser;
			req_s1.addr <= s_tdata;
			req_s1.tag  <= in_tag;
			set_s1      <= in_set;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rowv_s1     <= 1'b0;
			row_valid_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						rowv_s1 <= row_valid_q[in_set];
						state_q <= S_LOOK;
					end
				end
				S_LOOK: begin
					// write lands before the next read can be issued
					if (done) begin
						row_valid_q[set_s1] <= 1'b1;
						state_q             <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	sact_ram #(
		.WIDTH(sact_pkg::ROW_W),
		.DEPTH(sact_pkg::SETS)
	) u_row_ram (
		.clk  (clk),
		.we   (done),
		.waddr(set_s1),
		.wdata(new_row),
		.re   (in_acc),
		.raddr(in_set),
		.rdata(ram_rdata)
	);

	sact_lookup u_lookup (
		.row    (cur_row),
		.req    (req_s1),
		.mode   (mode),
		.new_row(new_row),
		.res    (res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (done) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			m_tdata <= {5'd0, res.write_back, res.victim, res.evicted, res.hit};
		end
	end

`ifndef NO_ASSERTIONS
	a_accept_to_look: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == S_LOOK))
		else $error("accepted request did not enter lookup");

	a_no_accept_in_look: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LOOK) |-> !s_tready)
		else $error("request port open during lookup");

	a_done_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> m_tvalid)
		else $error("row update without a result");

	a_evict_is_miss: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(res.hit && res.evicted))
		else $error("eviction reported on a hit");
`endif

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the set-associative cache tag controller: requests
// go in over the stream port, a shadow tag store predicts hit, eviction,
// victim and write-back for each one, and every result is checked in order.
// ----------------------------------------------------------------------------
module testbench;

	localparam int CLK_PERIOD  = 20;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 165;
	localparam int POOL_TAGS   = 6;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // [31:0] address
	logic [1:0]  s_tuser;   // [1:0] kind
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;   // [0] hit, [1] evicted, [33:2] victim, [34] write_back
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// shadow copy of the configuration registers
	logic       cfg_policy;
	logic [3:0] cfg_offset;
	logic [3:0] cfg_index;
	logic       cfg_inclusive;

	// shadow tag store, one entry per set and way
	logic                       way_valid     [sact_pkg::SETS][sact_pkg::WAYS];
	logic                       way_dirty     [sact_pkg::SETS][sact_pkg::WAYS];
	logic [31:0]                way_tag       [sact_pkg::SETS][sact_pkg::WAYS];
	logic [31:0]                way_line_addr [sact_pkg::SETS][sact_pkg::WAYS];
	logic [sact_pkg::AGE_W-1:0] way_age       [sact_pkg::SETS][sact_pkg::WAYS];

	sact_pkg::res_t pending_results[$];   // predicted lookups, oldest first
	int             mismatches = 0;
	int             send_gap_odds;        // percent chance of a sender gap per request
	int             stall_odds;           // percent chance per cycle of a receiver stall
	logic [31:0]    tag_pool [POOL_TAGS];

	set_assoc_cache_tag_controller u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Hard stop well past the slowest legal run with worst idling.
	initial begin
		#15_000_000;
		$display("status: fail");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Shadow tag store
	// ------------------------------------------------------------------------

	function automatic void reset_model();
		cfg_policy    = sact_pkg::POLICY_LRU;
		cfg_offset    = 4'd5;
		cfg_index     = 4'd8;
		cfg_inclusive = 1'b0;
		for (int s = 0; s < sact_pkg::SETS; s++) begin
			for (int w = 0; w < sact_pkg::WAYS; w++) begin
				way_valid[s][w] = 1'b0;
				way_dirty[s][w] = 1'b0;
				way_age[s][w]   = sact_pkg::AGE_W'(w);
			end
		end
	endfunction

	// Ages in a set stay a permutation: everything newer than the touched way
	// moves down one rank, the touched way becomes the newest.
	function automatic void promote_way(int set_no, int way);
		logic [sact_pkg::AGE_W-1:0] rank;
		rank = way_age[set_no][way];
		for (int v = 0; v < sact_pkg::WAYS; v++)
			if (way_age[set_no][v] > rank)
				way_age[set_no][v] = way_age[set_no][v] - 1'b1;
		way_age[set_no][way] = sact_pkg::AGE_W'(sact_pkg::WAYS - 1);
	endfunction

	function automatic sact_pkg::res_t predict_access(sact_pkg::kind_t kind,
		logic [31:0] addr);
		logic [63:0]    wide;
		logic [63:0]    tag;
		int             shift;
		int             set_no;
		int             hit_way;
		int             slot;
		sact_pkg::res_t r;
		wide   = {32'd0, addr};
		shift  = cfg_offset + cfg_index;
		tag    = wide >> shift;
		// index_bits beyond log2 SETS just wraps onto the physical sets
		set_no = int'(((wide >> cfg_offset) & ((64'd1 << cfg_index) - 64'd1))
			% sact_pkg::SETS);
		r      = '0;

		hit_way = -1;
		for (int w = 0; w < sact_pkg::WAYS; w++)
			if (hit_way < 0 && way_valid[set_no][w] && {32'd0, way_tag[set_no][w]} == tag)
				hit_way = w;

		// invalidate: never fills, never touches ages
		if (kind == sact_pkg::KIND_INVAL) begin
			if (hit_way >= 0) begin
				r.hit        = 1'b1;
				r.write_back = cfg_inclusive && way_dirty[set_no][hit_way];
				way_valid[set_no][hit_way] = 1'b0;
				way_dirty[set_no][hit_way] = 1'b0;
			end
			return r;
		end

		if (hit_way >= 0) begin
			r.hit = 1'b1;
			if (cfg_policy == sact_pkg::POLICY_LRU)
				promote_way(set_no, hit_way);
			slot = hit_way;
		end else begin
			// lowest invalid way first, else the oldest one goes
			slot = -1;
			for (int w = 0; w < sact_pkg::WAYS; w++)
				if (slot < 0 && !way_valid[set_no][w])
					slot = w;
			if (slot < 0) begin
				slot = 0;
				for (int w = 1; w < sact_pkg::WAYS; w++)
					if (way_age[set_no][w] < way_age[set_no][slot])
						slot = w;
				r.evicted    = 1'b1;
				r.victim     = way_line_addr[set_no][slot];
				r.write_back = way_dirty[set_no][slot];
			end
			way_valid[set_no][slot]     = 1'b1;
			way_dirty[set_no][slot]     = 1'b0;
			way_tag[set_no][slot]       = tag[31:0];
			way_line_addr[set_no][slot] = addr;
			promote_way(set_no, slot);
		end
		// write and the spare code both dirty the line
		if (kind != sact_pkg::KIND_READ)
			way_dirty[set_no][slot] = 1'b1;
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------------

	function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %h, got %h", $time, what, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin : result_check
		sact_pkg::res_t got;
		sact_pkg::res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.hit        = m_tdata[0];
			got.evicted    = m_tdata[1];
			got.victim     = m_tdata[33:2];
			got.write_back = m_tdata[34];
			if (pending_results.size() == 0) begin
				$display("%0t ns: result with nothing pending, expected none, got %h",
					$time, m_tdata);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				check_field("hit", 32'(want.hit), 32'(got.hit));
				check_field("evicted", 32'(want.evicted), 32'(got.evicted));
				check_field("victim_address", want.victim, got.victim);
				check_field("write_back", 32'(want.write_back), 32'(got.write_back));
			end
		end
	end

	// Result side back-pressure: random stall bursts, rate set per phase.
	initial begin : result_ready_driver
		int stall_left;
		stall_left = 0;
		m_tready   = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				m_tready   = 1'b0;
				stall_left = stall_left - 1;
			end else if (stall_odds != 0 && $urandom_range(1, 100) <= stall_odds) begin
				m_tready   = 1'b0;
				stall_left = $urandom_range(1, 16) - 1;
			end else begin
				m_tready = 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------------

	// One request; the prediction is taken at the accepting edge so it sees
	// the store exactly as the block does.
	task automatic send_request(sact_pkg::kind_t kind, logic [31:0] addr);
		sact_pkg::res_t want;
		if (send_gap_odds != 0 && $urandom_range(1, 100) <= send_gap_odds) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser  = kind;
		s_tdata  = addr;
		do @(posedge clk); while (!s_tready);
		want = predict_access(kind, addr);
		pending_results = {pending_results, want};
		@(negedge clk);
	endtask

	// Stop sending and let every outstanding lookup come back, plus the
	// pipeline depth, so the block is idle.
	task automatic settle();
		s_tvalid = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	// APB write followed by a read-back of the same register.
	task automatic write_reg(sact_pkg::reg_idx_t idx, logic [31:0] value);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {idx, 2'b00};
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			sact_pkg::REG_POLICY:    cfg_policy    = value[0];
			sact_pkg::REG_OFFSET:    cfg_offset    = value[3:0];
			sact_pkg::REG_INDEX:     cfg_index     = value[3:0];
			sact_pkg::REG_INCLUSIVE: cfg_inclusive = value[0];
			default: ;
		endcase
		@(negedge clk);
		pwrite  = 1'b0;
		penable = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		check_field("register read-back", value, prdata);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
	endtask

	task automatic configure(logic policy, logic [3:0] offset, logic [3:0] index,
		logic inclusive);
		settle();
		write_reg(sact_pkg::REG_POLICY, 32'(policy));
		write_reg(sact_pkg::REG_OFFSET, 32'(offset));
		write_reg(sact_pkg::REG_INDEX, 32'(index));
		write_reg(sact_pkg::REG_INCLUSIVE, 32'(inclusive));
	endtask

	// Build an address from tag / set / byte under the current split.
	function automatic logic [31:0] make_addr(logic [31:0] tag, logic [31:0] set_no,
		logic [31:0] byte_sel);
		logic [63:0] a;
		int          shift;
		shift = cfg_offset + cfg_index;
		a = ({32'd0, tag} << shift)
			| (({32'd0, set_no} & ((64'd1 << cfg_index) - 64'd1)) << cfg_offset)
			| ({32'd0, byte_sel} & ((64'd1 << cfg_offset) - 64'd1));
		return a[31:0];
	endfunction

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Cold misses, a hit, filling one set with read, write and spare requests,
	// then an LRU eviction of a dirty way.
	task automatic test_fill_and_evict();
		configure(sact_pkg::POLICY_LRU, 4'd5, 4'd8, 1'b0);
		send_request(sact_pkg::KIND_READ, 32'h0000_0000);
		send_request(sact_pkg::KIND_READ, 32'h0000_0000);
		send_request(sact_pkg::KIND_WRITE, 32'hFFFF_FFFF);
		send_request(sact_pkg::KIND_WRITE, make_addr(1, 0, 3));
		send_request(sact_pkg::KIND_SPARE, make_addr(2, 0, 0));
		send_request(sact_pkg::KIND_READ, make_addr(3, 0, 31));
		send_request(sact_pkg::KIND_READ, make_addr(0, 0, 0));   // refresh tag 0
		send_request(sact_pkg::KIND_READ, make_addr(4, 0, 0));   // tag 1 oldest, dirty
	endtask

	// Invalidate hit and miss, refill of the hole, then with the inclusive mode
	// on, write-back on invalidate of a dirty line and an invalidate miss.
	task automatic test_invalidate();
		send_request(sact_pkg::KIND_INVAL, make_addr(2, 0, 0));
		send_request(sact_pkg::KIND_INVAL, make_addr(2, 0, 0));
		send_request(sact_pkg::KIND_READ, make_addr(5, 0, 0));
		configure(sact_pkg::POLICY_LRU, 4'd5, 4'd8, 1'b1);
		send_request(sact_pkg::KIND_WRITE, make_addr(6, 0, 0));
		send_request(sact_pkg::KIND_INVAL, make_addr(6, 0, 0));
		send_request(sact_pkg::KIND_INVAL, make_addr(3, 0, 0));
	endtask

	// Split changes keep old lines; zero and oversized offset/index included.
	task automatic test_geometry_change();
		configure(sact_pkg::POLICY_LRU, 4'd0, 4'd0, 1'b0);
		send_request(sact_pkg::KIND_READ, 32'h0000_0000);
		send_request(sact_pkg::KIND_WRITE, 32'hFFFF_FFFF);
		configure(sact_pkg::POLICY_FIFO, 4'd8, 4'd8, 1'b1);
		send_request(sact_pkg::KIND_READ, 32'hFFFF_FFFF);
		configure(sact_pkg::POLICY_LRU, 4'd15, 4'd15, 1'b1);
		send_request(sact_pkg::KIND_READ, 32'hFFFF_FFFF);
		send_request(sact_pkg::KIND_WRITE, 32'h1234_5678);
	endtask

	// FIFO: a hit does not protect the first-filled way.
	task automatic test_fifo_order();
		configure(sact_pkg::POLICY_FIFO, 4'd5, 4'd8, 1'b0);
		for (int t = 0; t < sact_pkg::WAYS; t++)
			send_request(sact_pkg::KIND_READ, make_addr(t, 1, 0));
		send_request(sact_pkg::KIND_READ, make_addr(0, 1, 0));
		send_request(sact_pkg::KIND_READ, make_addr(4, 1, 0));
		send_request(sact_pkg::KIND_READ, make_addr(0, 1, 0));
	endtask

	// Mostly conflicting traffic into a few sets from a small tag pool, with
	// some fully random requests mixed in, across several settings.
	task automatic random_request();
		sact_pkg::kind_t kind;
		logic [31:0]     addr;
		int unsigned     pick;
		logic [31:0]     set_no;
		pick = $urandom_range(1, 100);
		if (pick <= 15) begin
			kind = sact_pkg::kind_t'($urandom_range(0, 3));
			addr = $urandom;
		end else begin
			pick = $urandom_range(1, 100);
			if (pick <= 45)
				kind = sact_pkg::KIND_READ;
			else if (pick <= 78)
				kind = sact_pkg::KIND_WRITE;
			else if (pick <= 92)
				kind = sact_pkg::KIND_INVAL;
			else
				kind = sact_pkg::KIND_SPARE;
			set_no = $urandom_range(0, 3);
			if (set_no == 3)
				set_no = 32'hFFFF_FFFF;   // top set of the current index width
			addr = make_addr(tag_pool[$urandom_range(0, POOL_TAGS - 1)], set_no, $urandom);
		end
		send_request(kind, addr);
	endtask

	task automatic test_random_traffic();
		int unsigned settings [PHASES][4] = '{
			'{0, 5, 8, 0}, '{1, 0, 0, 1}, '{0, 8, 8, 1}, '{1, 4, 2, 0},
			'{0, 2, 12, 1}, '{1, 8, 1, 1}, '{0, 0, 8, 0}, '{1, 3, 4, 1}
		};
		int shift;
		for (int p = 0; p < PHASES; p++) begin
			configure(1'(settings[p][0]), 4'(settings[p][1]), 4'(settings[p][2]),
				1'(settings[p][3]));
			// last phase runs flat out on both sides
			send_gap_odds = (p == PHASES - 1 || p % 3 == 0) ? 0 : $urandom_range(5, 30);
			stall_odds    = (p == PHASES - 1 || p % 3 == 1) ? 0 : $urandom_range(5, 30);
			shift = cfg_offset + cfg_index;
			tag_pool[0] = 32'd0;
			tag_pool[1] = 32'hFFFF_FFFF >> shift;
			for (int i = 2; i < POOL_TAGS; i++)
				tag_pool[i] = $urandom >> shift;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (i == PHASE_ITEMS / 2)
					settle();   // full drain mid-phase, then resume
				random_request();
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------

	initial begin
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		s_tuser       = sact_pkg::KIND_READ;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		send_gap_odds = 15;
		stall_odds    = 15;
		reset_model();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_fill_and_evict();
		test_invalidate();
		test_geometry_change();
		test_fifo_order();
		test_random_traffic();

		settle();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
